### design/min_runtime_thread_scheduler_core_macros.svh
// assertion macros used by the scheduler checker file
`ifndef MIN_RUNTIME_THREAD_SCHEDULER_CORE_MACROS_SVH
`define MIN_RUNTIME_THREAD_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MRTS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MRTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mrts_pkg.sv
// shared types and constants of the least-runtime thread scheduler
package mrts_pkg;

    // request opcodes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_SLEEP = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_SCHED = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_BAD_SLOT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_QUANTUM = 2'd0;
    localparam logic [1:0] CFG_MIN_QUANTUM = 2'd1;
    localparam logic [1:0] CFG_PENALTY     = 2'd2;
    localparam logic [1:0] CFG_TICKS_PER_MS = 2'd3;

    // configuration reset values
    localparam logic [9:0] MAX_QUANTUM_RST  = 10'd100;
    localparam logic [9:0] MIN_QUANTUM_RST  = 10'd10;
    localparam logic [6:0] PENALTY_RST      = 7'd1;
    localparam logic [9:0] TICKS_PER_MS_RST = 10'd1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // field widths
    localparam int OP_W     = 2;
    localparam int SLOT_F_W = 4;
    localparam int NICE_W   = 6;
    localparam int WAKE_W   = 32;
    localparam int NOW_W    = 48;
    localparam int STATUS_W = 2;
    localparam int SLICE_W  = 32;
    localparam int WOKEN_W  = 5;
    localparam int RT_W     = 64;
    localparam int STAMP_W  = 32;
    localparam int TICK_W   = 32;

    // input tdata layout
    localparam int IN_SLOT_LSB = 0;
    localparam int IN_NICE_LSB = IN_SLOT_LSB + SLOT_F_W;
    localparam int IN_WAKE_LSB = IN_NICE_LSB + NICE_W;
    localparam int IN_NOW_LSB  = IN_WAKE_LSB + WAKE_W;
    localparam int IN_DATA_W   = 96;

    // output tdata layout
    localparam int OUT_NEXT_LSB  = 0;
    localparam int OUT_SLICE_LSB = OUT_NEXT_LSB + SLOT_F_W;
    localparam int OUT_WOKEN_LSB = OUT_SLICE_LSB + SLICE_W;
    localparam int OUT_DATA_W    = 48;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic post;
        logic avg_take;
        logic share_take;
        logic qmul;
        logic qsum;
        logic tmul;
        logic charge;
        logic out_load;
    } mrts_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       scan_done;
        logic       n_zero;
        logic       div_done;
    } mrts_stat_t;

endpackage

### design/mrts_ram.sv
// generic single-write, single-read ram with registered read data
module mrts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/mrts_div.sv
// restoring divider, one quotient bit per cycle
module mrts_div #(
    parameter int DIV_W = 12,
    parameter int DVS_W = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;

    // one shift-subtract step
    always_comb begin
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### design/mrts_datapath.sv
// slot table, scan, quantum arithmetic and result registers
module mrts_datapath
    import mrts_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [OP_W-1:0]       in_op,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  mrts_cmd_t             cmd,
    output mrts_stat_t            stat,
    output logic [STATUS_W-1:0]   out_status,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int TOT_W  = NICE_W + CNT_W;
    localparam int DIV_W  = (TOT_W > 10) ? TOT_W : 10;
    localparam int MS_W   = 17;
    localparam int TKS_W  = MS_W + 10;

    // configuration
    logic [9:0] max_q_reg, min_q_reg, tpm_reg;
    logic [6:0] pen_reg;

    // latched request
    logic [OP_W-1:0]     op_reg, op_next;
    logic [SLOT_F_W-1:0] slot_reg, slot_next;
    logic [NICE_W-1:0]   nice_in_reg, nice_in_next;
    logic [WAKE_W-1:0]   wake_in_reg, wake_in_next;
    logic [NOW_W-1:0]    now_reg, now_next;

    // scheduler state
    logic [SLOTS-1:0]   valid_reg, valid_next;
    logic [SLOTS-1:0]   runnable_reg, runnable_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [STAMP_W-1:0] stamp_cnt_reg, stamp_cnt_next;
    logic [SLOT_W-1:0]  running_slot_reg, running_slot_next;
    logic               running_valid_reg, running_valid_next;
    logic [NOW_W-1:0]   last_start_reg, last_start_next;

    // scan
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic              eval_valid_reg, eval_valid_next;
    logic [SLOT_W-1:0] eval_idx_reg, eval_idx_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  woke_reg, woke_next;
    logic [SLOT_W-1:0] best_idx_reg, best_idx_next;
    logic [RT_W-1:0]   best_rt_reg, best_rt_next;
    logic [STAMP_W-1:0] best_st_reg, best_st_next;
    logic [NICE_W-1:0] best_nice_reg, best_nice_next;

    // quantum arithmetic
    logic [NICE_W-1:0]  avg_reg, avg_next;
    logic [9:0]         share_reg, share_next;
    logic signed [15:0] prod_reg, prod_next;
    logic [MS_W-1:0]    ms_reg, ms_next;
    logic [TKS_W-1:0]   ticks_reg, ticks_next;
    logic signed [7:0]  nice_diff;
    logic signed [17:0] q_sum;

    // result and output registers
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SLOT_F_W-1:0] res_next_reg, res_next_next;
    logic [SLICE_W-1:0]  res_slice_reg, res_slice_next;
    logic [WOKEN_W-1:0]  res_woken_reg, res_woken_next;
    logic [STATUS_W-1:0] o_status_reg, o_status_next;
    logic [OUT_DATA_W-1:0] o_data_reg, o_data_next;

    // ram ports
    logic [SLOT_W-1:0]  raddr;
    logic               rt_we, nice_we, wake_we, st_we;
    logic [SLOT_W-1:0]  rt_waddr, st_waddr;
    logic [RT_W-1:0]    rt_wdata, rt_rdata;
    logic [NICE_W-1:0]  nice_rdata;
    logic [WAKE_W-1:0]  wake_rdata;
    logic [STAMP_W-1:0] st_rdata;

    // divider
    logic             div_start, div_done;
    logic [DIV_W-1:0] div_dividend, div_quotient;

    logic [SLOT_W-1:0] slot_idx;
    logic              slot_bad, sleep_ok, add_ok;
    logic              e_valid, e_run, wake_hit, cand, better;
    logic [NOW_W-1:0]  delta;

    assign slot_idx = SLOT_W'(slot_reg);
    assign slot_bad = ({28'd0, slot_reg} >= 32'(SLOTS));
    assign add_ok   = cmd.exec && (op_reg == OP_ADD) && !slot_bad;
    assign sleep_ok = !slot_bad && valid_reg[slot_idx];
    assign delta    = now_reg - last_start_reg;

    assign e_valid  = valid_reg[eval_idx_reg];
    assign e_run    = runnable_reg[eval_idx_reg];
    assign wake_hit = cmd.scan && eval_valid_reg && (op_reg == OP_TICK) && e_valid && !e_run
                      && (tick_reg >= wake_rdata);
    assign cand     = cmd.scan && eval_valid_reg && (op_reg == OP_SCHED) && e_valid && e_run;
    assign better   = (n_reg == '0) || (rt_rdata < best_rt_reg)
                      || ((rt_rdata == best_rt_reg) && (st_rdata < best_st_reg));

    // ram addressing and writes
    always_comb begin
        raddr    = cmd.tmul ? running_slot_reg : scan_cnt_reg[SLOT_W-1:0];
        rt_we    = add_ok || (cmd.charge && running_valid_reg);
        rt_waddr = cmd.exec ? slot_idx : running_slot_reg;
        rt_wdata = cmd.exec ? '0 : (rt_rdata + {16'd0, delta});
        nice_we  = add_ok;
        wake_we  = cmd.exec && (op_reg == OP_SLEEP) && sleep_ok;
        st_we    = add_ok || wake_hit;
        st_waddr = cmd.exec ? slot_idx : eval_idx_reg;
    end

    // divider operand selection
    always_comb begin
        div_start    = (cmd.post && (op_reg == OP_SCHED) && (n_reg != '0)) || cmd.avg_take;
        div_dividend = cmd.post ? DIV_W'(total_reg) : DIV_W'(max_q_reg);
    end

    // quantum terms
    always_comb begin
        nice_diff = $signed({2'b00, avg_reg}) - $signed({2'b00, best_nice_reg});
        q_sum     = $signed({8'd0, share_reg}) + prod_reg;
    end

    // next-state logic
    always_comb begin
        op_next            = op_reg;
        slot_next          = slot_reg;
        nice_in_next       = nice_in_reg;
        wake_in_next       = wake_in_reg;
        now_next           = now_reg;
        valid_next         = valid_reg;
        runnable_next      = runnable_reg;
        tick_next          = tick_reg;
        stamp_cnt_next     = stamp_cnt_reg;
        running_slot_next  = running_slot_reg;
        running_valid_next = running_valid_reg;
        last_start_next    = last_start_reg;
        scan_cnt_next      = scan_cnt_reg;
        eval_valid_next    = eval_valid_reg;
        eval_idx_next      = eval_idx_reg;
        n_next             = n_reg;
        total_next         = total_reg;
        woke_next          = woke_reg;
        best_idx_next      = best_idx_reg;
        best_rt_next       = best_rt_reg;
        best_st_next       = best_st_reg;
        best_nice_next     = best_nice_reg;
        avg_next           = avg_reg;
        share_next         = share_reg;
        prod_next          = prod_reg;
        ms_next            = ms_reg;
        ticks_next         = ticks_reg;
        res_status_next    = res_status_reg;
        res_next_next      = res_next_reg;
        res_slice_next     = res_slice_reg;
        res_woken_next     = res_woken_reg;
        o_status_next      = o_status_reg;
        o_data_next        = o_data_reg;

        // take a new request
        if (cmd.load) begin
            op_next         = in_op;
            slot_next       = in_data[IN_SLOT_LSB +: SLOT_F_W];
            nice_in_next    = in_data[IN_NICE_LSB +: NICE_W];
            wake_in_next    = in_data[IN_WAKE_LSB +: WAKE_W];
            now_next        = in_data[IN_NOW_LSB +: NOW_W];
            if (in_op == OP_TICK) begin
                tick_next = tick_reg + TICK_W'(1);
            end
            scan_cnt_next   = '0;
            eval_valid_next = 1'b0;
            n_next          = '0;
            total_next      = '0;
            woke_next       = '0;
            res_status_next = STATUS_OK;
            res_next_next   = '0;
            res_slice_next  = '0;
            res_woken_next  = '0;
        end

        // add and sleep
        if (cmd.exec) begin
            if (op_reg == OP_ADD) begin
                if (slot_bad) begin
                    res_status_next = STATUS_BAD_SLOT;
                end else begin
                    valid_next[slot_idx]    = 1'b1;
                    runnable_next[slot_idx] = 1'b1;
                    stamp_cnt_next          = stamp_cnt_reg + STAMP_W'(1);
                end
            end else begin
                if (sleep_ok) begin
                    runnable_next[slot_idx] = 1'b0;
                end else begin
                    res_status_next = STATUS_BAD_SLOT;
                end
            end
        end

        // walk the table, one entry per cycle
        if (cmd.scan) begin
            if (scan_cnt_reg < CNT_W'(SLOTS)) begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
            end
            eval_valid_next = (scan_cnt_reg < CNT_W'(SLOTS));
            eval_idx_next   = scan_cnt_reg[SLOT_W-1:0];
            if (wake_hit) begin
                runnable_next[eval_idx_reg] = 1'b1;
                stamp_cnt_next              = stamp_cnt_reg + STAMP_W'(1);
                woke_next                   = woke_reg + CNT_W'(1);
            end
            if (cand) begin
                if (better) begin
                    best_idx_next  = eval_idx_reg;
                    best_rt_next   = rt_rdata;
                    best_st_next   = st_rdata;
                    best_nice_next = nice_rdata;
                end
                total_next = total_reg + TOT_W'(nice_rdata);
                n_next     = n_reg + CNT_W'(1);
            end
        end

        // after the scan
        if (cmd.post) begin
            if (op_reg == OP_TICK) begin
                res_woken_next = WOKEN_W'(woke_reg);
            end else if (n_reg == '0) begin
                res_status_next = STATUS_EMPTY;
            end
        end

        if (cmd.avg_take) begin
            avg_next = div_quotient[NICE_W-1:0];
        end
        if (cmd.share_take) begin
            share_next = div_quotient[9:0];
        end
        if (cmd.qmul) begin
            prod_next = nice_diff * $signed({1'b0, pen_reg});
        end
        if (cmd.qsum) begin
            ms_next = (q_sum <= 18'sd0) ? MS_W'(min_q_reg) : q_sum[MS_W-1:0];
        end
        if (cmd.tmul) begin
            ticks_next = ms_reg * tpm_reg;
        end

        // charge the previous thread and switch
        if (cmd.charge) begin
            running_slot_next  = best_idx_reg;
            running_valid_next = 1'b1;
            last_start_next    = now_reg;
            res_next_next      = SLOT_F_W'(best_idx_reg);
            res_slice_next     = SLICE_W'(ticks_reg);
        end

        if (cmd.out_load) begin
            o_status_next = res_status_reg;
            o_data_next   = {7'd0, res_woken_reg, res_slice_reg, res_next_reg};
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_q_reg <= MAX_QUANTUM_RST;
            min_q_reg <= MIN_QUANTUM_RST;
            pen_reg   <= PENALTY_RST;
            tpm_reg   <= TICKS_PER_MS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAX_QUANTUM:  max_q_reg <= cfg_wdata;
                CFG_MIN_QUANTUM:  min_q_reg <= cfg_wdata;
                CFG_PENALTY:      pen_reg   <= cfg_wdata[6:0];
                CFG_TICKS_PER_MS: tpm_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg            <= OP_ADD;
            valid_reg         <= '0;
            runnable_reg      <= '0;
            tick_reg          <= '0;
            stamp_cnt_reg     <= '0;
            running_slot_reg  <= '0;
            running_valid_reg <= 1'b0;
            last_start_reg    <= '0;
            scan_cnt_reg      <= '0;
            eval_valid_reg    <= 1'b0;
            n_reg             <= '0;
            woke_reg          <= '0;
        end else begin
            op_reg            <= op_next;
            valid_reg         <= valid_next;
            runnable_reg      <= runnable_next;
            tick_reg          <= tick_next;
            stamp_cnt_reg     <= stamp_cnt_next;
            running_slot_reg  <= running_slot_next;
            running_valid_reg <= running_valid_next;
            last_start_reg    <= last_start_next;
            scan_cnt_reg      <= scan_cnt_next;
            eval_valid_reg    <= eval_valid_next;
            n_reg             <= n_next;
            woke_reg          <= woke_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        slot_reg       <= slot_next;
        nice_in_reg    <= nice_in_next;
        wake_in_reg    <= wake_in_next;
        now_reg        <= now_next;
        eval_idx_reg   <= eval_idx_next;
        total_reg      <= total_next;
        best_idx_reg   <= best_idx_next;
        best_rt_reg    <= best_rt_next;
        best_st_reg    <= best_st_next;
        best_nice_reg  <= best_nice_next;
        avg_reg        <= avg_next;
        share_reg      <= share_next;
        prod_reg       <= prod_next;
        ms_reg         <= ms_next;
        ticks_reg      <= ticks_next;
        res_status_reg <= res_status_next;
        res_next_reg   <= res_next_next;
        res_slice_reg  <= res_slice_next;
        res_woken_reg  <= res_woken_next;
        o_status_reg   <= o_status_next;
        o_data_reg     <= o_data_next;
    end

    // per-slot stores
    mrts_ram #(.WIDTH(RT_W), .DEPTH(SLOTS)) u_rt_ram (
        .aclk  (aclk),
        .we    (rt_we),
        .waddr (rt_waddr),
        .wdata (rt_wdata),
        .raddr (raddr),
        .rdata (rt_rdata)
    );

    mrts_ram #(.WIDTH(NICE_W), .DEPTH(SLOTS)) u_nice_ram (
        .aclk  (aclk),
        .we    (nice_we),
        .waddr (slot_idx),
        .wdata (nice_in_reg),
        .raddr (raddr),
        .rdata (nice_rdata)
    );

    mrts_ram #(.WIDTH(WAKE_W), .DEPTH(SLOTS)) u_wake_ram (
        .aclk  (aclk),
        .we    (wake_we),
        .waddr (slot_idx),
        .wdata (wake_in_reg),
        .raddr (raddr),
        .rdata (wake_rdata)
    );

    mrts_ram #(.WIDTH(STAMP_W), .DEPTH(SLOTS)) u_stamp_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (stamp_cnt_reg),
        .raddr (raddr),
        .rdata (st_rdata)
    );

    mrts_div #(.DIV_W(DIV_W), .DVS_W(CNT_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (n_reg),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // status toward the controller
    always_comb begin
        stat.op        = op_reg;
        stat.scan_done = eval_valid_reg && (eval_idx_reg == SLOT_W'(SLOTS - 1));
        stat.n_zero    = (n_reg == '0);
        stat.div_done  = div_done;
    end

    assign out_status = o_status_reg;
    assign out_data   = o_data_reg;

endmodule

### design/mrts_ctrl.sv
// sequencing state machine and output valid of the scheduler
module mrts_ctrl
    import mrts_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic [OP_W-1:0] in_op,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  mrts_stat_t      stat,
    output mrts_cmd_t       cmd
);

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b00000000001,
        ST_EXEC      = 11'b00000000010,
        ST_SCAN      = 11'b00000000100,
        ST_POST      = 11'b00000001000,
        ST_DIV_AVG   = 11'b00000010000,
        ST_DIV_SHARE = 11'b00000100000,
        ST_QMUL      = 11'b00001000000,
        ST_QSUM      = 11'b00010000000,
        ST_TMUL      = 11'b00100000000,
        ST_CHARGE    = 11'b01000000000,
        ST_DONE      = 11'b10000000000
    } mrts_state_t;

    mrts_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    // state transitions and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if ((in_op == OP_ADD) || (in_op == OP_SLEEP)) begin
                        state_next = ST_EXEC;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                cmd.post = 1'b1;
                if ((stat.op == OP_TICK) || stat.n_zero) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV_AVG;
                end
            end
            ST_DIV_AVG: begin
                if (stat.div_done) begin
                    cmd.avg_take = 1'b1;
                    state_next   = ST_DIV_SHARE;
                end
            end
            ST_DIV_SHARE: begin
                if (stat.div_done) begin
                    cmd.share_take = 1'b1;
                    state_next     = ST_QMUL;
                end
            end
            ST_QMUL: begin
                cmd.qmul   = 1'b1;
                state_next = ST_QSUM;
            end
            ST_QSUM: begin
                cmd.qsum   = 1'b1;
                state_next = ST_TMUL;
            end
            ST_TMUL: begin
                cmd.tmul   = 1'b1;
                state_next = ST_CHARGE;
            end
            ST_CHARGE: begin
                cmd.charge = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

### design/min_runtime_thread_scheduler_core.sv
// top level of the least-runtime-first thread scheduler
//
// Takes one request at a time: add and sleep run a single execute step; a tick
// walks the slot table at one entry per cycle; a schedule walks the table the
// same way, then runs two divisions on the shared one-bit-per-cycle divider
// (total nice by runnable count, max quantum by runnable count) and a short
// multiply chain. An empty queue ends a schedule right after the table walk.
// A finished result waits in the output register and the next request is
// taken once it has been moved there.
module min_runtime_thread_scheduler_core
    import mrts_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // slot, nice_level, wake_tick, now_cycles
    input  logic [OP_W-1:0]       s_tuser,   // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // next_slot, timeslice_ticks, woken_count
    output logic [STATUS_W-1:0]   m_tuser    // status
);

    mrts_cmd_t  cmd;
    mrts_stat_t stat;

    mrts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_op    (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mrts_datapath #(.SLOTS(SLOTS)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_op      (s_tuser),
        .in_data    (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_status (m_tuser),
        .out_data   (m_tdata)
    );

endmodule

### design/mrts_checker.sv
// port-level checks of the scheduler and their binding
`include "min_runtime_thread_scheduler_core_macros.svh"

module mrts_checker
    import mrts_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]   m_tuser
);

    // a stalled result holds
    `MRTS_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // failed requests report no slot, slice or woken count
    `MRTS_ASSERT_NOW(a_error_fields_zero, aclk, aresetn, m_tvalid && (m_tuser != STATUS_OK), m_tdata == '0, "error result carries data")

    // no more threads wake than there are slots
    `MRTS_ASSERT_NOW(a_woken_bound, aclk, aresetn, m_tvalid, m_tdata[OUT_WOKEN_LSB +: WOKEN_W] <= SLOTS, "woken count above slot count")

    // one request in flight at a time
    `MRTS_ASSERT_NEXT(a_single_request, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request taken while busy")

endmodule

bind min_runtime_thread_scheduler_core mrts_checker #(.SLOTS(SLOTS)) u_mrts_checker (.*);
